// ===== rtl/tpba_pkg.sv =====
// Shared types and codes for the buffer pool allocator.
`default_nettype none
package tpba_pkg;
   localparam int unsigned KindBits = 4;
   localparam logic [KindBits-1:0] KIND_REUSED        = 4'd0;
   localparam logic [KindBits-1:0] KIND_GROWN         = 4'd1;
   localparam logic [KindBits-1:0] KIND_CREATED       = 4'd2;
   localparam logic [KindBits-1:0] KIND_FREED         = 4'd3;
   localparam logic [KindBits-1:0] KIND_FREE_UNKNOWN  = 4'd4;
   localparam logic [KindBits-1:0] KIND_ALLOC_FULL    = 4'd5;
   localparam logic [KindBits-1:0] KIND_FREE_OVERFLOW = 4'd6;
   localparam logic [KindBits-1:0] KIND_RELEASE_ENTRY = 4'd7;
   localparam logic [KindBits-1:0] KIND_RELEASE_EMPTY = 4'd8;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam int unsigned TypeBits  = 8;
   localparam int unsigned RatioBits = 8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture request beat
      logic scan_step;   // evaluate free entry at scan index
      logic shift_step;  // one compaction step
      logic commit;      // apply decision
      logic rel_step;    // output one release entry
      logic clear;       // empty both lists
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic shift_done;
      logic rel_done;
   } stat_type;
endpackage
`default_nettype wire

// ===== rtl/tpba_datapath.sv =====
// Datapath: list storage, scan compare, winner registers and result formation.
`default_nettype none
module tpba_datapath
   import tpba_pkg::*;
#(
   parameter int unsigned FREE_DEPTH  = 16,
   parameter int unsigned USED_DEPTH  = 16,
   parameter int unsigned DIM_BITS    = 16,
   parameter int unsigned HANDLE_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output      stat_type               stat,
   input  wire logic [RatioBits-1:0]   ratio,
   input  wire logic [1:0]             in_op,
   input  wire logic [DIM_BITS-1:0]    in_w,
   input  wire logic [DIM_BITS-1:0]    in_h,
   input  wire logic [TypeBits-1:0]    in_t,
   input  wire logic [HANDLE_BITS-1:0] in_fresh,
   input  wire logic [HANDLE_BITS-1:0] in_fh,
   output      logic [KindBits-1:0]    o_kind,
   output      logic [HANDLE_BITS-1:0] o_handle,
   output      logic [DIM_BITS-1:0]    o_w,
   output      logic [DIM_BITS-1:0]    o_h,
   output      logic [HANDLE_BITS-1:0] o_old,
   output      logic                   o_oldv,
   output      logic                   o_last
);
   localparam int unsigned FIW = $clog2(FREE_DEPTH + 1);
   localparam int unsigned UIW = $clog2(USED_DEPTH + 1);
   localparam int unsigned FAW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
   localparam int unsigned UAW = (USED_DEPTH > 1) ? $clog2(USED_DEPTH) : 1;
   localparam int unsigned PW  = DIM_BITS + RatioBits + 1;
   localparam int unsigned TW  = (FIW > UIW ? FIW : UIW) + 1;

   typedef struct packed {
      logic [DIM_BITS-1:0]    w;
      logic [DIM_BITS-1:0]    h;
      logic [TypeBits-1:0]    t;
      logic [HANDLE_BITS-1:0] hd;
   } ent_type;

   ent_type free_mem [FREE_DEPTH];
   ent_type used_mem [USED_DEPTH];

   logic [FIW-1:0] fcnt_ff, fcnt_in;
   logic [UIW-1:0] ucnt_ff, ucnt_in;
   logic [1:0]     op_ff;
   logic [DIM_BITS-1:0] w_ff, h_ff;
   logic [TypeBits-1:0] t_ff;
   logic [HANDLE_BITS-1:0] fresh_ff, fh_ff;

   // Scan and search registers.
   logic [TW-1:0]  idx_ff, idx_in;
   logic           found_ff;
   logic [FAW-1:0] best_ff;
   logic [UAW-1:0] hit_ff;
   logic [DIM_BITS-1:0] ax_ff, ay_ff, wx_ff, wy_ff, nx_ff, ny_ff;
   logic           shft_free_ff;
   logic [TW-1:0]  sidx_ff;

   // Current free and used entries at the scan index.
   ent_type fe, ue;
   assign fe = free_mem[idx_ff[FAW-1:0]];
   assign ue = used_mem[idx_ff[UAW-1:0]];

   function automatic logic too_far(input logic [DIM_BITS-1:0] a,
                                    input logic [DIM_BITS-1:0] b,
                                    input logic [RatioBits-1:0] r);
      logic [PW-1:0] prod;
      begin
         prod = PW'({1'b0, r} + 9'd1) * PW'(b);
         too_far = PW'(a) >= prod;
      end
   endfunction

   // Candidate evaluation for the entry under scan.
   logic [DIM_BITS-1:0] gx, gy, cax, cay, cwx, cwy;
   logic elig, better;
   always_comb begin
      gx  = (fe.w > w_ff) ? fe.w : w_ff;
      gy  = (fe.h > h_ff) ? fe.h : h_ff;
      cax = gx - fe.w;
      cay = gy - fe.h;
      cwx = gx - w_ff;
      cwy = gy - h_ff;
      elig = (fe.t == t_ff) && !too_far(w_ff, fe.w, ratio) && !too_far(fe.w, w_ff, ratio)
             && !too_far(h_ff, fe.h, ratio) && !too_far(fe.h, h_ff, ratio);
      better = !found_ff || (ax_ff != 0 && cax < ax_ff) || (ay_ff != 0 && cay < ay_ff)
               || (ax_ff == cax && cwx < wx_ff) || (ay_ff == cay && cwy < wy_ff);
   end

   // Status toward the controller. The counters already hold their reduced
   // values while compaction runs, so the last slot to fill is count - 1.
   always_comb begin
      stat.scan_done = (op_ff == OP_ALLOC) ? (idx_ff >= TW'(fcnt_ff))
                                           : (idx_ff == '0);
      stat.shift_done = shft_free_ff ? (sidx_ff >= TW'(fcnt_ff))
                                     : (sidx_ff >= TW'(ucnt_ff));
      stat.rel_done = (idx_ff + 1'b1 >= TW'(ucnt_ff) + TW'(fcnt_ff));
   end

   logic reuse, grow;
   assign reuse = found_ff && ax_ff == '0 && ay_ff == '0;
   assign grow  = found_ff && !reuse && (ax_ff <= w_ff || ay_ff <= h_ff);

   logic ufull, ffull;
   assign ufull = ucnt_ff >= UIW'(USED_DEPTH);
   assign ffull = fcnt_ff >= FIW'(FREE_DEPTH);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff <= '0;
         ucnt_ff <= '0;
      end else begin
         fcnt_ff <= fcnt_in;
         ucnt_ff <= ucnt_in;
      end
   end

   // Decision result and counters.
   always_comb begin
      fcnt_in = fcnt_ff;
      ucnt_in = ucnt_ff;
      if (cmd.clear) begin
         fcnt_in = '0;
         ucnt_in = '0;
      end else if (cmd.commit) begin
         if (op_ff == OP_ALLOC) begin
            if (!ufull) begin
               ucnt_in = ucnt_ff + 1'b1;
               if (reuse || grow) fcnt_in = fcnt_ff - 1'b1;
            end
         end else if (found_ff && !ffull) begin
            fcnt_in = fcnt_ff + 1'b1;
            ucnt_in = ucnt_ff - 1'b1;
         end
      end
   end

   // Output result register, plus working registers and list storage.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= in_op;
         w_ff     <= in_w;
         h_ff     <= in_h;
         t_ff     <= in_t;
         fresh_ff <= in_fresh;
         fh_ff    <= in_fh;
         found_ff <= 1'b0;
         ax_ff <= '0; ay_ff <= '0; wx_ff <= '0; wy_ff <= '0;
         idx_ff   <= (in_op == OP_FREE) ? TW'(ucnt_ff) : '0;
      end else if (cmd.scan_step) begin
         if (op_ff == OP_ALLOC) begin
            if (elig && better) begin
               found_ff <= 1'b1;
               ax_ff <= cax; ay_ff <= cay; wx_ff <= cwx; wy_ff <= cwy;
               nx_ff <= gx;  ny_ff <= gy;
               best_ff <= idx_ff[FAW-1:0];
            end
            idx_ff <= idx_ff + 1'b1;
         end else begin
            // Search the used list from its end for the handle.
            if (used_mem[UAW'(idx_ff - 1'b1)].hd == fh_ff) begin
               found_ff <= 1'b1;
               hit_ff   <= UAW'(idx_ff - 1'b1);
               idx_ff   <= '0;
            end else begin
               idx_ff <= idx_ff - 1'b1;
            end
         end
      end else if (cmd.rel_step) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.commit) begin
         o_last <= 1'b1;
         idx_ff <= '0;
         if (op_ff == OP_ALLOC) begin
            if (ufull) begin
               o_kind <= KIND_ALLOC_FULL; o_handle <= '0;
               o_w <= '0; o_h <= '0; o_old <= '0; o_oldv <= 1'b0;
               shft_free_ff <= 1'b0; sidx_ff <= TW'(USED_DEPTH);
            end else if (reuse) begin
               o_kind <= KIND_REUSED; o_handle <= free_mem[best_ff].hd;
               o_w <= free_mem[best_ff].w; o_h <= free_mem[best_ff].h;
               o_old <= '0; o_oldv <= 1'b0;
               shft_free_ff <= 1'b1; sidx_ff <= TW'(best_ff);
               used_mem[ucnt_ff[UAW-1:0]] <= free_mem[best_ff];
            end else if (grow) begin
               o_kind <= KIND_GROWN; o_handle <= fresh_ff;
               o_w <= nx_ff; o_h <= ny_ff;
               o_old <= free_mem[best_ff].hd; o_oldv <= 1'b1;
               shft_free_ff <= 1'b1; sidx_ff <= TW'(best_ff);
               used_mem[ucnt_ff[UAW-1:0]] <= '{w: nx_ff, h: ny_ff, t: t_ff, hd: fresh_ff};
            end else begin
               o_kind <= KIND_CREATED; o_handle <= fresh_ff;
               o_w <= w_ff; o_h <= h_ff;
               o_old <= '0; o_oldv <= 1'b0;
               shft_free_ff <= 1'b1; sidx_ff <= TW'(FREE_DEPTH);
               used_mem[ucnt_ff[UAW-1:0]] <= '{w: w_ff, h: h_ff, t: t_ff, hd: fresh_ff};
            end
         end else begin
            o_handle <= fh_ff;
            o_w <= '0; o_h <= '0; o_old <= '0; o_oldv <= 1'b0;
            shft_free_ff <= 1'b0;
            if (!found_ff) begin
               o_kind <= KIND_FREE_UNKNOWN; sidx_ff <= TW'(USED_DEPTH);
            end else if (ffull) begin
               o_kind <= KIND_FREE_OVERFLOW; sidx_ff <= TW'(USED_DEPTH);
            end else begin
               o_kind <= KIND_FREED; sidx_ff <= TW'(hit_ff);
               free_mem[fcnt_ff[FAW-1:0]] <= used_mem[hit_ff];
            end
         end
      end else if (cmd.shift_step) begin
         // Close the gap left by the removed entry, one slot a cycle.
         if (shft_free_ff)
            free_mem[sidx_ff[FAW-1:0]] <= free_mem[FAW'(sidx_ff + 1'b1)];
         else
            used_mem[sidx_ff[UAW-1:0]] <= used_mem[UAW'(sidx_ff + 1'b1)];
         sidx_ff <= sidx_ff + 1'b1;
      end
      if (cmd.rel_step) begin
         o_w <= '0; o_h <= '0; o_old <= '0; o_oldv <= 1'b0;
         if (ucnt_ff == '0 && fcnt_ff == '0) begin
            o_kind <= KIND_RELEASE_EMPTY; o_handle <= '0; o_last <= 1'b1;
         end else begin
            o_kind <= KIND_RELEASE_ENTRY;
            o_handle <= (idx_ff < TW'(ucnt_ff)) ? ue.hd
                        : free_mem[FAW'(idx_ff - TW'(ucnt_ff))].hd;
            o_last <= stat.rel_done;
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/tpba_ctrl.sv =====
// Controller state machine for the allocator.
`default_nettype none
module tpba_ctrl
   import tpba_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_fire,
   input  wire logic [1:0] req_op,
   input  wire logic     rsp_tready,
   input  wire stat_type stat,
   output      cmd_type  cmd,
   output      logic     req_ready,
   output      logic     rsp_valid
);
   localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_COMMIT = 3'd2, S_SHIFT = 3'd3,
                          S_SEND = 3'd4, S_REL = 3'd5, S_RSEND = 3'd6, S_WAIT = 3'd7;
   logic [2:0] st_ff, st_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   assign req_ready = (st_ff == S_IDLE);
   assign rsp_valid = (st_ff == S_SEND) || (st_ff == S_RSEND) || (st_ff == S_WAIT);

   // Sequencing: scan, commit, compaction, then deliver; a release streams entries, then clears both lists.
   always_comb begin
      st_in = st_ff;
      cmd   = '0;
      unique case (st_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               if (req_op == OP_RELEASE) st_in = S_REL;
               else if (req_op == OP_ALLOC || req_op == OP_FREE) st_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) st_in = S_COMMIT;
            else cmd.scan_step = 1'b1;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            st_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (stat.shift_done) st_in = S_SEND;
            else cmd.shift_step = 1'b1;
         end
         S_SEND: begin
            if (rsp_tready) st_in = S_IDLE;
         end
         S_REL: begin
            cmd.rel_step = 1'b1;
            st_in = stat.rel_done ? S_WAIT : S_RSEND;
         end
         S_RSEND: begin
            if (rsp_tready) begin
               cmd.rel_step = 1'b1;
               if (stat.rel_done) st_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (rsp_tready) begin
               cmd.clear = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/texture_pool_best_fit_allocator_core.sv =====
// Top level of the best-fit buffer pool allocator.
// Allocate: free entries scanned one per cycle, a commit step, then entries moved one per cycle;
// the result beat is offered once compaction is done.
// Free: the same shape over the used list, one entry searched or moved per cycle.
// Release: a release step forms the first beat after accept; the rest follow one per cycle while the consumer is ready.
// One request at a time; reset empties both lists and sets the ratio to 5.
`default_nettype none
module texture_pool_best_fit_allocator_core
   import tpba_pkg::*;
#(
   parameter int unsigned FREE_DEPTH  = 16,
   parameter int unsigned USED_DEPTH  = 16,
   parameter int unsigned DIM_BITS    = 16,
   parameter int unsigned HANDLE_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output      logic req_tready,
   // op, req_width, req_height, type_code, fresh_handle, free_handle (low bit up)
   input  wire logic [((2 + 2*DIM_BITS + 8 + 2*HANDLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output      logic rsp_tvalid,
   input  wire logic rsp_tready,
   // kind, handle, granted_width, granted_height, old_handle, old_handle_valid (low bit up)
   output      logic [((4 + 2*HANDLE_BITS + 2*DIM_BITS + 1 + 7) / 8) * 8 - 1:0] rsp_tdata,
   output      logic rsp_tlast,
   input  wire logic csr_valid,
   output      logic csr_ready,
   input  wire logic [RatioBits-1:0] csr_data
);
   localparam int unsigned OW = ((4 + 2*HANDLE_BITS + 2*DIM_BITS + 1 + 7) / 8) * 8;
   localparam int unsigned PADW = OW - (4 + 2*HANDLE_BITS + 2*DIM_BITS + 1);

   logic [RatioBits-1:0] ratio_ff;
   cmd_type  cmd;
   stat_type stat;
   logic [KindBits-1:0] o_kind;
   logic [HANDLE_BITS-1:0] o_handle, o_old;
   logic [DIM_BITS-1:0] o_w, o_h;
   logic o_oldv;

   // Ratio register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) ratio_ff <= RatioBits'(5);
      else if (csr_valid) ratio_ff <= csr_data;
   end

   tpba_ctrl u_ctrl (
      .clock, .reset,
      .req_fire (req_tvalid && req_tready),
      .req_op   (req_tdata[1:0]),
      .rsp_tready,
      .stat, .cmd,
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid)
   );

   tpba_datapath #(
      .FREE_DEPTH(FREE_DEPTH), .USED_DEPTH(USED_DEPTH),
      .DIM_BITS(DIM_BITS), .HANDLE_BITS(HANDLE_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .stat,
      .ratio    (ratio_ff),
      .in_op    (req_tdata[1:0]),
      .in_w     (req_tdata[2 +: DIM_BITS]),
      .in_h     (req_tdata[2+DIM_BITS +: DIM_BITS]),
      .in_t     (req_tdata[2+2*DIM_BITS +: TypeBits]),
      .in_fresh (req_tdata[2+2*DIM_BITS+TypeBits +: HANDLE_BITS]),
      .in_fh    (req_tdata[2+2*DIM_BITS+TypeBits+HANDLE_BITS +: HANDLE_BITS]),
      .o_kind, .o_handle, .o_w, .o_h, .o_old, .o_oldv,
      .o_last   (rsp_tlast)
   );

   assign rsp_tdata = {{PADW{1'b0}}, o_oldv, o_old, o_h, o_w, o_handle, o_kind};
endmodule
`default_nettype wire
